FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the base64 decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define B64D_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define B64D_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define B64D_ASSERT(name, clk, rst_n, prop, msg)
`define B64D_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup for the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_OK     = 2'd1,
    KIND_HALTED = 2'd2,
    KIND_LENGTH = 2'd3
  } b64d_kind_t;

  // One entry per accepted character that yields results.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            has_status;
    b64d_kind_t      status;
  } b64d_job_t;

  // bit 6 set: not in the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] s;
    s = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      s = 7'd62;
    end else if (c == 8'h2F) begin
      s = 7'd63;
    end
    return s;
  endfunction

endpackage

FILE: hdl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks quantum state and builds result jobs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // end_of_message
  input  logic       q_full,
  output logic       q_push,
  output b64d_job_t  q_job
);

  logic [1:0]  pos_r, pos_nxt;
  logic [17:0] held_r, held_nxt;
  logic        pad_r, pad_nxt;
  logic        halted_r, halted_nxt;

  logic        accept;
  logic [6:0]  sx;
  logic        invalid;
  logic        is_pad;
  logic [17:0] held_cur;
  logic        pad_cur;
  logic [5:0]  s1, s2, s3;
  b64d_job_t   job;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign sx        = sextet_of(in_tdata);
  assign invalid   = sx[6];
  assign is_pad    = (in_tdata == PAD_CHAR);

  assign held_cur = (pos_r == 2'd0) ? 18'd0 : held_r;
  assign pad_cur  = (pos_r == 2'd0) ? 1'b0 : pad_r;
  assign s1 = held_cur[17:12];
  assign s2 = held_cur[11:6];
  assign s3 = held_cur[5:0];

  always_comb begin
    held_nxt   = held_r;
    pad_nxt    = pad_r;
    halted_nxt = halted_r;
    pos_nxt    = pos_r + 2'd1;
    job        = '0;
    job.status = KIND_OK;
    job.bytes[0] = {s1, s2[5:4]};
    job.bytes[1] = {s2[3:0], s3[5:2]};
    job.bytes[2] = {s3[1:0], sx[5:0]};
    if (!halted_r) begin
      held_nxt = held_cur;
      pad_nxt  = pad_cur;
      if (pos_r == 2'd3) begin
        if (pad_cur) begin
          job.nbytes = 2'd1;
        end else if (is_pad) begin
          job.nbytes = 2'd2;
        end else if (invalid) begin
          halted_nxt = 1'b1;
        end else begin
          job.nbytes = 2'd3;
        end
      end else if (pos_r == 2'd2 && is_pad) begin
        pad_nxt  = 1'b1;
        held_nxt = {held_cur[11:0], 6'd0};
      end else if (invalid) begin
        halted_nxt = 1'b1;
      end else begin
        held_nxt = {held_cur[11:0], sx[5:0]};
      end
    end
    if (in_tlast) begin
      job.has_status = 1'b1;
      if (pos_r != 2'd3) begin
        job.status = KIND_LENGTH;
      end else if (halted_nxt) begin
        job.status = KIND_HALTED;
      end else begin
        job.status = KIND_OK;
      end
      pos_nxt    = 2'd0;
      held_nxt   = '0;
      pad_nxt    = 1'b0;
      halted_nxt = 1'b0;
    end
  end

  assign q_job  = job;
  assign q_push = accept && (job.has_status || job.nbytes != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      held_r   <= '0;
      pad_r    <= 1'b0;
      halted_r <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      held_r   <= held_nxt;
      pad_r    <= pad_nxt;
      halted_r <= halted_nxt;
    end
  end

  `B64D_ASSERT(a_eom_clears, clk, rst_n, (accept && in_tlast) |=> (pos_r == 2'd0 && !halted_r), "state not cleared after end of message")

endmodule

FILE: hdl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Small register FIFO of jobs between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  b64d_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output b64d_job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  b64d_job_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head_job  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  `B64D_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full, "push into full queue")
  `B64D_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, not_empty, "pop from empty queue")

endmodule

FILE: hdl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Unpacks jobs into single result words behind an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  b64d_job_t  job,
  output logic       job_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic [1:0] out_tuser,   // [1:0] kind
  output logic       out_tlast    // last_of_run
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r;
  logic [7:0] byte_r;
  b64d_kind_t kind_r;
  logic       last_r;

  logic       load;
  logic       is_byte;
  logic       is_last;
  logic [7:0] cur_byte;

  assign load    = job_valid && (!vld_r || out_tready);
  assign is_byte = (idx_r < job.nbytes);
  assign is_last = job.has_status ? (idx_r == job.nbytes)
                                  : (idx_r == job.nbytes - 2'd1);
  assign job_pop = load && is_last;
  assign idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;

  always_comb begin
    case (idx_r)
      2'd0:    cur_byte = job.bytes[0];
      2'd1:    cur_byte = job.bytes[1];
      2'd2:    cur_byte = job.bytes[2];
      default: cur_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= idx_nxt;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= is_byte ? cur_byte : 8'd0;
      kind_r <= is_byte ? KIND_DATA : job.status;
      last_r <= is_last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  `B64D_ASSERT_IMPL(a_idx_has_job, clk, rst_n, idx_r != 2'd0, job_valid, "mid-job index without a job")

endmodule

FILE: hdl/base64_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder, one character in per word, one result out per word.
// ----------------------------------------------------------------------------
// Input channel in_*: one character per word in in_tdata, in_tlast marks the
// final character of a message. Output channel out_*: out_tdata is a decoded
// byte or zero, out_tuser is the kind (data, ok, halted, length error) and
// out_tlast flags the final result caused by one input character.
// A character is taken every cycle while the job queue has room. A character
// that completes a valid quantum or ends a message queues one job; the back end
// sends one result word per cycle while out_tready is high; a job gives one to
// four words. With an empty queue and a free output register, the first result
// of a character passes through the queue and then the output register. Input
// throughput is one character per cycle while the queue has room; output is one
// word per cycle while out_tready is high, set by the single output register,
// and the queue of QUEUE_DEPTH jobs absorbs bursts. When the receiver stalls the
// output register holds, the queue fills and in_tready drops only when full.
// Synchronous reset clears the quantum state, the queue and the output valid.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // end_of_message
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast   // last_of_run
);

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_not_empty;
  b64d_job_t q_in_job;
  b64d_job_t q_head_job;

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_in_job)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_in_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (q_head_job)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (q_not_empty),
    .job        (q_head_job),
    .job_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
